// ===== rtl/sctr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_pkg: shared types and constants of the signal change trace recorder
// Field structs, command codes and ring geometry.
// ----------------------------------------------------------------------------
package sctr_pkg;

  localparam int SIGNALS   = 256;
  localparam int SAMPLES   = 32;
  localparam int LANES     = 4;
  localparam int BLOCK_W   = 64;
  localparam int TIME_W    = 48;
  localparam int SIG_W     = $clog2(SIGNALS);
  localparam int SLOT_W    = $clog2(SAMPLES);
  localparam int LSIG_W    = SIG_W - $clog2(LANES);
  localparam int ADDR_W    = LSIG_W + SLOT_W;
  localparam int LDEPTH    = (SIGNALS / LANES) * SAMPLES;
  localparam int LBITS     = BLOCK_W / LANES;
  localparam int LBIT_W    = $clog2(LBITS);

  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] capture_time;
    logic [1:0]        block_index;
    logic [63:0]       block_values;
    logic [63:0]       block_changed;
    logic              last_block;
    logic [7:0]        query_signal;
    logic [TIME_W-1:0] window_begin;
    logic [TIME_W-1:0] window_end;
  } in_beat_t;

  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic              sample_value;
    logic              has_sample;
    logic              run_last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAPT,
    ST_QPTR,
    ST_QSET,
    ST_QRD,
    ST_QEVAL,
    ST_OUT
  } state_t;

  // per-lane capture job
  typedef struct packed {
    logic              start;
    logic [1:0]        blk;
    logic [LBITS-1:0]  mask;
    logic [LBITS-1:0]  vals;
    logic [TIME_W-1:0] t;
  } lane_job_t;

endpackage

// ===== rtl/signal_change_trace_recorder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_change_trace_recorder: per-signal sample ring trace buffer
// Four capture lanes share each block; a query walk reads one signal's ring.
//
//   channel | direction | handshake
//   in      | input     | in_valid / in_ready, in_beat_t
//   out     | output    | out_valid / out_ready, out_beat_t
//   cfg     | input     | cfg_we / cfg_wdata, no wait
//
// A capture beat holds in_ready low until the slowest lane has scanned its
// bits up to its last changed bit, with a pointer read and a ring write for
// each changed bit. A query fetches the ring pointers, then reads each ring
// entry in turn and issues result beats, waiting while out_ready stays low.
// Restart clears the rings as it is accepted. Reset is synchronous; the
// sample stores are not cleared, ring valid bits are.
// ----------------------------------------------------------------------------
module signal_change_trace_recorder
  import sctr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data,
  input  logic      cfg_we,
  input  logic [8:0] cfg_wdata
);

  state_t state, state_next;

  logic [8:0]        signals_in_use;
  logic              capture_all;
  logic              clear;
  lane_job_t         job [LANES];
  logic [LANES-1:0]  busy;

  logic [TIME_W:0]   qdata [LANES];
  logic [SLOT_W-1:0] qnew [LANES];
  logic [SLOT_W-1:0] qold [LANES];
  logic [LANES-1:0]  qne;

  logic [1:0]        qlane;
  logic [LSIG_W-1:0] qsig;
  logic [SLOT_W-1:0] cur, endslot;
  logic [TIME_W-1:0] wbegin, wend;
  logic [TIME_W-1:0] qtime;
  logic              qlevel;
  logic              hit;
  logic              stop;
  out_beat_t         pend;
  logic              have_pend;
  logic              walk_done;

  logic [SIG_W:0]    used;
  logic [63:0]       inuse, chg;
  logic              accept;

  assign accept = in_valid && in_ready;
  assign used = (signals_in_use > 9'(SIGNALS)) ? (SIG_W+1)'(SIGNALS)
                                              : (SIG_W+1)'(signals_in_use);

  // in-use mask of the addressed block
  always_comb begin
    logic [SIG_W:0] lo;
    lo = (SIG_W+1)'({in_data.block_index, 6'd0});
    if (used >= lo + (SIG_W+1)'(64)) begin
      inuse = '1;
    end else if (used <= lo) begin
      inuse = '0;
    end else begin
      inuse = (64'd1 << 6'(used - lo)) - 64'd1;
    end
    chg = capture_all ? inuse : (in_data.block_changed & inuse);
  end

  // deal block bits across lanes: bit b goes to lane b mod LANES
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      job[l].start = accept && (in_data.command == CMD_CAPTURE);
      job[l].blk   = in_data.block_index;
      job[l].t     = in_data.capture_time;
      for (int b = 0; b < LBITS; b++) begin
        job[l].mask[b] = chg[b*LANES + l];
        job[l].vals[b] = in_data.block_values[b*LANES + l];
      end
    end
  end

  assign clear = accept && (in_data.command == CMD_RESTART);

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    sctr_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .clear      (clear),
      .job        (job[l]),
      .busy       (busy[l]),
      .qsig       (qsig),
      .qslot      (cur),
      .qdata      (qdata[l]),
      .q_newest   (qnew[l]),
      .q_oldest   (qold[l]),
      .q_nonempty (qne[l])
    );
  end

  // configuration and capture-all flag
  always_ff @(posedge clk) begin
    if (rst) begin
      signals_in_use <= 9'd256;
      capture_all    <= 1'b1;
    end else begin
      if (cfg_we) begin
        signals_in_use <= cfg_wdata;
      end
      if (clear) begin
        capture_all <= 1'b1;
      end else if (accept && in_data.command == CMD_CAPTURE && in_data.last_block) begin
        capture_all <= 1'b0;
      end
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // entry under evaluation in the walked ring
  assign qtime  = qdata[qlane][TIME_W:1];
  assign qlevel = qdata[qlane][0];
  assign hit    = qtime < wend;
  assign stop   = (qtime < wbegin) || (cur == endslot);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_CAPTURE: state_next = ST_CAPT;
            CMD_QUERY:   state_next = ST_QPTR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_CAPT:  state_next = (|busy) ? ST_CAPT : ST_IDLE;
      ST_QPTR:  state_next = qne[qlane] ? ST_QSET : ST_OUT;
      ST_QSET:  state_next = ST_QRD;
      ST_QRD:   state_next = ST_QEVAL;
      ST_QEVAL: state_next = (stop || (hit && have_pend)) ? ST_OUT : ST_QRD;
      ST_OUT: begin
        if (out_ready) begin
          if (out_data.run_last) begin
            state_next = ST_IDLE;
          end else if (walk_done) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_QRD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // query walk; hold one found sample back until the next one or the end
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      qlane     <= in_data.query_signal[1:0];
      qsig      <= in_data.query_signal[SIG_W-1:2];
      wbegin    <= in_data.window_begin;
      wend      <= in_data.window_end;
      have_pend <= 1'b0;
      walk_done <= 1'b0;
    end else if (state == ST_QPTR) begin
      out_data <= '{sample_time: '0, sample_value: 1'b0, has_sample: 1'b0,
                    run_last: 1'b1};
    end else if (state == ST_QSET) begin
      cur     <= qnew[qlane];
      endslot <= qold[qlane];
    end else if (state == ST_QEVAL) begin
      cur <= SLOT_W'((32'(cur) + SAMPLES - 1) % SAMPLES);
      if (hit) begin
        if (have_pend) begin
          out_data  <= pend;
          pend      <= '{sample_time: qtime, sample_value: qlevel, has_sample: 1'b1,
                         run_last: 1'b0};
          walk_done <= stop;
        end else if (stop) begin
          out_data <= '{sample_time: qtime, sample_value: qlevel, has_sample: 1'b1,
                        run_last: 1'b1};
        end else begin
          pend      <= '{sample_time: qtime, sample_value: qlevel, has_sample: 1'b1,
                         run_last: 1'b0};
          have_pend <= 1'b1;
        end
      end else if (stop) begin
        if (have_pend) begin
          out_data <= '{sample_time: pend.sample_time, sample_value: pend.sample_value,
                        has_sample: 1'b1, run_last: 1'b1};
        end else begin
          out_data <= '{sample_time: '0, sample_value: 1'b0, has_sample: 1'b0,
                        run_last: 1'b1};
        end
      end
    end else if (state == ST_OUT && out_ready && walk_done) begin
      // flush the held sample as the final beat
      out_data  <= '{sample_time: pend.sample_time, sample_value: pend.sample_value,
                     has_sample: 1'b1, run_last: 1'b1};
      walk_done <= 1'b0;
    end
  end

endmodule

// ===== rtl/sctr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sctr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/sctr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_lane: one capture lane
// Owns the rings of every signal whose bit index mod LANES equals the lane
// number; walks its share of a block, one ring update per changed bit over
// two steps (pointer read, then sample and pointer write), and serves query
// reads from its pointer and sample stores.
// ----------------------------------------------------------------------------
module sctr_lane
  import sctr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  lane_job_t         job,
  output logic              busy,
  input  logic [LSIG_W-1:0] qsig,
  input  logic [SLOT_W-1:0] qslot,
  output logic [TIME_W:0]   qdata,
  output logic [SLOT_W-1:0] q_newest,
  output logic [SLOT_W-1:0] q_oldest,
  output logic              q_nonempty
);

  localparam int RINGS = SIGNALS / LANES;

  logic [RINGS-1:0]  nonempty;

  logic [LBITS-1:0]  mask;
  logic [LBITS-1:0]  vals;
  logic [1:0]        blk;
  logic [TIME_W-1:0] t;
  logic [LBIT_W-1:0] bitn;
  logic              phase;

  logic              we;
  logic [ADDR_W-1:0] addr;
  logic [LSIG_W-1:0] rsig;
  logic [SLOT_W-1:0] head;

  logic [LSIG_W-1:0]   ptr_addr;
  logic [2*SLOT_W-1:0] ptr_wdata;
  logic [2*SLOT_W-1:0] ptr_rdata;
  logic [SLOT_W-1:0]   newest_rd;
  logic [SLOT_W-1:0]   oldest_rd;
  logic [SLOT_W-1:0]   oldest_next;

  assign busy = |mask;
  // ring number inside lane: block*LBITS + bit
  assign rsig = LSIG_W'({blk, bitn});
  // write step of a changed bit: pointers are back from the pointer store
  assign we   = busy && phase;

  assign newest_rd = ptr_rdata[2*SLOT_W-1:SLOT_W];
  assign oldest_rd = ptr_rdata[SLOT_W-1:0];
  assign head = nonempty[rsig] ? SLOT_W'((32'(newest_rd) + 1) % SAMPLES) : '0;
  // drop the oldest entry when the head catches up with it
  assign oldest_next = !nonempty[rsig] ? '0 :
                       (head == oldest_rd) ? SLOT_W'((32'(oldest_rd) + 1) % SAMPLES)
                                           : oldest_rd;

  assign ptr_addr  = busy ? rsig : qsig;
  assign ptr_wdata = {head, oldest_next};
  assign addr      = we ? {rsig, head} : {qsig, qslot};

  assign q_newest   = newest_rd;
  assign q_oldest   = oldest_rd;
  assign q_nonempty = nonempty[qsig];

  sctr_ram #(.WIDTH(2 * SLOT_W), .DEPTH(RINGS)) u_ptr (
    .clk   (clk),
    .we    (we),
    .addr  (ptr_addr),
    .wdata (ptr_wdata),
    .rdata (ptr_rdata)
  );

  sctr_ram #(.WIDTH(TIME_W + 1), .DEPTH(LDEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata ({t, vals[bitn]}),
    .rdata (qdata)
  );

  // walk the lane's changed bits: read pointers, then write the ring head
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      nonempty <= '0;
      mask     <= '0;
      bitn     <= '0;
      phase    <= 1'b0;
    end else if (job.start) begin
      mask  <= job.mask;
      vals  <= job.vals;
      blk   <= job.blk;
      t     <= job.t;
      bitn  <= '0;
      phase <= 1'b0;
    end else if (busy) begin
      if (phase) begin
        mask[bitn]     <= 1'b0;
        nonempty[rsig] <= 1'b1;
        bitn           <= bitn + 1'b1;
        phase          <= 1'b0;
      end else if (mask[bitn]) begin
        phase <= 1'b1;
      end else begin
        bitn <= bitn + 1'b1;
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the signal change trace recorder
// A queue-fed driver offers capture, query and restart beats in random bursts;
// a clocked monitor compares each output beat against a behavioral ring model.
// ----------------------------------------------------------------------------
module tb;
  import sctr_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_we;
  logic [8:0] cfg_wdata;

  signal_change_trace_recorder u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // behavioral ring state
  logic [TIME_W-1:0] trace_time [SIGNALS*SAMPLES];
  logic              trace_level[SIGNALS*SAMPLES];
  int unsigned       head_slot  [SIGNALS];
  int unsigned       tail_slot  [SIGNALS];
  bit                ring_live  [SIGNALS];
  bit                snap_all;
  int unsigned       in_use;

  in_beat_t  pending_beats[$];
  out_beat_t expected_samples[$];
  int        fail_count = 0;
  int        beats_checked = 0;
  int        query_count = 0;
  int        capture_count = 0;
  bit        long_hold;
  longint    cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_trace();
    for (int s = 0; s < SIGNALS; s++) begin
      head_slot[s] = 0;
      tail_slot[s] = 0;
      ring_live[s] = 1'b0;
    end
    snap_all = 1'b1;
  endfunction

  function automatic logic [63:0] block_mask(int unsigned blk);
    int unsigned used;
    int unsigned lo;
    used = (in_use > SIGNALS) ? SIGNALS : in_use;
    lo = blk * 64;
    if (used >= lo + 64) return '1;
    if (used <= lo) return '0;
    return (64'd1 << (used - lo)) - 64'd1;
  endfunction

  // advance the model by one accepted beat, queue expected output beats
  function automatic void apply_beat(in_beat_t b);
    logic [63:0] chg;
    int unsigned sg;
    int unsigned hd;
    int unsigned cur;
    int          n;
    out_beat_t   r;
    logic [TIME_W-1:0] t;
    case (cmd_t'(b.command))
      CMD_CAPTURE: begin
        chg = snap_all ? block_mask(b.block_index)
                       : (b.block_changed & block_mask(b.block_index));
        for (int bit_i = 0; bit_i < 64; bit_i++) begin
          sg = b.block_index * 64 + bit_i;
          if (chg[bit_i] && sg < SIGNALS) begin
            if (!ring_live[sg]) begin
              hd = 0;
              tail_slot[sg] = 0;
              ring_live[sg] = 1'b1;
            end else begin
              hd = (head_slot[sg] + 1) % SAMPLES;
              if (hd == tail_slot[sg]) tail_slot[sg] = (tail_slot[sg] + 1) % SAMPLES;
            end
            head_slot[sg] = hd;
            trace_time[sg*SAMPLES+hd] = b.capture_time;
            trace_level[sg*SAMPLES+hd] = b.block_values[bit_i];
          end
        end
        if (b.last_block) snap_all = 1'b0;
        capture_count++;
      end
      CMD_QUERY: begin
        sg = b.query_signal;
        n = 0;
        query_count++;
        if (sg < SIGNALS && ring_live[sg]) begin
          cur = head_slot[sg];
          for (int k = 0; k < SAMPLES; k++) begin
            t = trace_time[sg*SAMPLES+cur];
            if (t < b.window_end) begin
              r.sample_time = t;
              r.sample_value = trace_level[sg*SAMPLES+cur];
              r.has_sample = 1'b1;
              r.run_last = 1'b0;
              expected_samples.push_back(r);
              n++;
            end
            if (t < b.window_begin || cur == tail_slot[sg]) break;
            cur = (cur + SAMPLES - 1) % SAMPLES;
          end
        end
        if (n == 0) begin
          r = '0;
          r.run_last = 1'b1;
          expected_samples.push_back(r);
        end else begin
          r = expected_samples.pop_back();
          r.run_last = 1'b1;
          expected_samples.push_back(r);
        end
      end
      CMD_RESTART: clear_trace();
      default: ;
    endcase
  endfunction

  // driver: bursts of beats with random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
      clear_trace();
    end else begin
      if (in_valid && in_ready) apply_beat(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus an optional long hold-off
  int stall_phase;
  int hold_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
      hold_left <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (long_hold && hold_left == 0) hold_left <= 400;
      if (hold_left > 1) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        if (hold_left == 1) hold_left <= -1;
        if ((stall_phase / 40) % 3 == 0) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
      end
    end
  end

  // monitor: compare each output beat with the oldest expectation
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected output beat time=%0h", out_data.sample_time);
        fail_count++;
      end else begin
        e = expected_samples.pop_front();
        beats_checked++;
        if (out_data.sample_time !== e.sample_time) begin
          $error("sample_time exp %0h got %0h", e.sample_time, out_data.sample_time);
          fail_count++;
        end
        if (out_data.sample_value !== e.sample_value) begin
          $error("sample_value exp %0b got %0b", e.sample_value, out_data.sample_value);
          fail_count++;
        end
        if (out_data.has_sample !== e.has_sample) begin
          $error("has_sample exp %0b got %0b", e.has_sample, out_data.has_sample);
          fail_count++;
        end
        if (out_data.run_last !== e.run_last) begin
          $error("run_last exp %0b got %0b", e.run_last, out_data.run_last);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic in_beat_t rand_beat(cmd_t c);
    in_beat_t b;
    b.command = c;
    b.capture_time = TIME_W'({$urandom, $urandom});
    b.block_index = 2'($urandom_range(0, 3));
    b.block_values = {$urandom, $urandom};
    b.block_changed = {$urandom, $urandom};
    b.last_block = 1'($urandom_range(0, 1));
    b.query_signal = 8'($urandom);
    b.window_begin = TIME_W'({$urandom, $urandom});
    b.window_end = TIME_W'({$urandom, $urandom});
    return b;
  endfunction

  // snapshot of four blocks at one capture time; signals mostly sparse
  task automatic push_snapshot(logic [TIME_W-1:0] t);
    in_beat_t b;
    for (int k = 0; k < 4; k++) begin
      b = rand_beat(CMD_CAPTURE);
      b.capture_time = t;
      b.block_index = 2'(k);
      if ($urandom_range(0, 2) != 0) b.block_changed = b.block_changed & {$urandom, $urandom};
      b.last_block = (k == 3);
      pending_beats.push_back(b);
    end
  endtask

  task automatic push_query(logic [TIME_W-1:0] tnow);
    in_beat_t b;
    b = rand_beat(CMD_QUERY);
    case ($urandom_range(0, 3))
      0: begin b.window_begin = '0; b.window_end = '1; end
      1: begin
        b.window_end = TIME_W'($urandom_range(0, 32'(tnow + TIME_W'(2))));
        b.window_begin = (b.window_end > TIME_W'(300))
                         ? b.window_end - TIME_W'($urandom_range(0, 300)) : '0;
      end
      2: begin
        b.window_begin = tnow - TIME_W'($urandom_range(0, 40));
        b.window_end = tnow + TIME_W'(1);
      end
      default: ;
    endcase
    pending_beats.push_back(b);
  endtask

  task automatic drain_all();
    while (pending_beats.size() > 0 || in_valid || !in_ready ||
           expected_samples.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_in_use(logic [8:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    in_use = v;
  endtask

  initial begin
    in_beat_t b;
    logic [TIME_W-1:0] now_t;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    long_hold = 1'b0;
    in_use = 256;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: queries on empty rings, capture-all, extremes, unknown command
    write_in_use(9'd256);
    b = rand_beat(CMD_QUERY); b.query_signal = 8'd0; pending_beats.push_back(b);
    b = rand_beat(CMD_QUERY); b.query_signal = 8'd255; pending_beats.push_back(b);
    b = rand_beat(CMD_CAPTURE); b.capture_time = '0; b.block_values = '0;
    b.block_index = 2'd0; b.last_block = 1'b0; pending_beats.push_back(b);
    b.capture_time = '1; b.block_values = '1; b.block_changed = '1;
    b.block_index = 2'd3; b.last_block = 1'b1; pending_beats.push_back(b);
    b = rand_beat(CMD_NONE); pending_beats.push_back(b);
    b = rand_beat(CMD_QUERY); b.query_signal = 8'd0; b.window_begin = '0;
    b.window_end = '1; pending_beats.push_back(b);
    b.query_signal = 8'd255; b.window_end = '1; pending_beats.push_back(b);
    b.window_end = '0; pending_beats.push_back(b);
    b.query_signal = 8'd200; b.window_begin = '1; b.window_end = '1;
    pending_beats.push_back(b);
    // overflow one ring past its depth
    for (int i = 0; i < SAMPLES + 3; i++) begin
      b = rand_beat(CMD_CAPTURE); b.capture_time = 48'd100 + TIME_W'(i);
      b.block_index = 2'd1;
      b.block_changed = 64'h1; b.last_block = 1'b1; pending_beats.push_back(b);
    end
    b = rand_beat(CMD_QUERY); b.query_signal = 8'd64; b.window_begin = '0;
    b.window_end = '1; pending_beats.push_back(b);
    b = rand_beat(CMD_RESTART); pending_beats.push_back(b);
    b = rand_beat(CMD_QUERY); b.query_signal = 8'd64; pending_beats.push_back(b);
    drain_all();

    // random phases over several register settings
    now_t = '0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_in_use(9'd1);
        1: write_in_use(9'd100);
        2: write_in_use(9'd511);
        3: write_in_use(9'd0);
        default: write_in_use(9'd256);
      endcase
      if (ph == 2) long_hold = 1'b1;
      b = rand_beat(CMD_RESTART); pending_beats.push_back(b);
      for (int i = 0; i < 46; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            now_t += TIME_W'($urandom_range(1, 20));
            push_snapshot(now_t);
            i += 3;
          end
          3, 4, 5, 6: push_query(now_t);
          7: pending_beats.push_back(rand_beat(cmd_t'($urandom_range(0, 3))));
          8: begin
            now_t += TIME_W'($urandom_range(1, 20));
            b = rand_beat(CMD_CAPTURE); b.capture_time = now_t;
            pending_beats.push_back(b);
          end
          default: push_query(now_t);
        endcase
      end
      drain_all();
    end

    $display("covered %0d captures, %0d queries, %0d output beats checked",
             capture_count, query_count, beats_checked);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
